[rtl/qma_pkg.sv]
// qma_pkg: shared constants for the quaternion mean accumulator.
// Holds sequencer state codes and fixed field widths; no dependencies.
package qma_pkg;

  localparam int QW      = 16;  // quaternion component / mean width
  localparam int WGT_W   = 16;  // weight width
  localparam int CNT_OUT = 24;  // atom_count port width
  localparam int NORM_MSB = 29; // normalized max lies in [2^29, 2^30)

  localparam int ST_W = 4;
  localparam logic [ST_W-1:0] S_IDLE  = 4'd0;
  localparam logic [ST_W-1:0] S_MUL   = 4'd1;
  localparam logic [ST_W-1:0] S_ADD   = 4'd2;
  localparam logic [ST_W-1:0] S_NORM  = 4'd3;
  localparam logic [ST_W-1:0] S_SQ    = 4'd4;
  localparam logic [ST_W-1:0] S_SQACC = 4'd5;
  localparam logic [ST_W-1:0] S_ROOT  = 4'd6;
  localparam logic [ST_W-1:0] S_DIV   = 4'd7;
  localparam logic [ST_W-1:0] S_DONE  = 4'd8;

endpackage

[rtl/quaternion_mean_accumulator.sv]
// quaternion_mean_accumulator: weighted quaternion sum with unit-length output.
// Depends on qma_pkg (state codes, field widths).
//
// Usage:
//   Input channel (in_valid/in_ready) carries one transaction: a Q1.15
//   quaternion, a weight, mode and start_req. The output channel
//   (out_valid/out_ready) returns one transaction per input: the running
//   sum scaled to unit length, the zero_sum and saturated flags, and the
//   atom count.
//   After acceptance the item is multiplied and added into each of the four
//   sums in turn, normalized by a shift of at most max(SUM_BITS-30, 29) bit
//   positions at one bit per cycle, squared and summed, square-rooted and
//   divided per component before out_valid; the next item is accepted only
//   after the result loads. An all-zero sum skips straight to the result
//   after accumulation. The square root is bit-serial (32 steps) and the
//   divider restoring (FRAC_BITS+1 steps per component).
//   in_ready is high whenever the sequencer is idle, also while a finished
//   result still waits in the output register; if the receiver stalls, the
//   next item runs and then holds in its final step until the output frees.
//   Reset clears the sums, the count, the clip flag and out_valid.
module quaternion_mean_accumulator
  import qma_pkg::*;
#(
  parameter int SUM_BITS   = 48,
  parameter int COUNT_BITS = 24,
  parameter int FRAC_BITS  = 15
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    mode,
  input  logic                    start_req,
  input  logic signed [QW-1:0]    in_w,
  input  logic signed [QW-1:0]    in_x,
  input  logic signed [QW-1:0]    in_y,
  input  logic signed [QW-1:0]    in_z,
  input  logic [WGT_W-1:0]        weight,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [QW-1:0]    mean_w,
  output logic signed [QW-1:0]    mean_x,
  output logic signed [QW-1:0]    mean_y,
  output logic signed [QW-1:0]    mean_z,
  output logic                    zero_sum,
  output logic                    saturated,
  output logic [CNT_OUT-1:0]      atom_count
);

  // Count arithmetic is wide enough for either the count or the weight.
  localparam int CW   = ((COUNT_BITS > WGT_W) ? COUNT_BITS : WGT_W) + 1;
  localparam int QB   = FRAC_BITS + 1;          // quotient bits
  localparam int QX   = (QB > QW + 1) ? QB : QW + 1;
  localparam int DCW  = $clog2(QB);
  localparam logic [CW-1:0] CNT_MAX = CW'((64'd1 << COUNT_BITS) - 64'd1);

  logic [ST_W-1:0]              state;
  logic [1:0]                   idx;
  logic signed [QW-1:0]         qin [4];
  logic [WGT_W-1:0]             wgt;
  logic signed [SUM_BITS-1:0]   sums [4];
  logic [COUNT_BITS-1:0]        count;
  logic                         clip;
  logic signed [QW+WGT_W:0]     prod;
  logic [SUM_BITS-1:0]          mag [4];
  logic [SUM_BITS-1:0]          mmax;
  logic [59:0]                  sq;
  logic [61:0]                  acc;
  logic [63:0]                  rv;
  logic [63:0]                  res;
  logic [4:0]                   k;
  logic [30:0]                  len;
  logic [32:0]                  rem;
  logic [QB-1:0]                quo;
  logic [DCW-1:0]               dcnt;
  logic signed [QW-1:0]         mres [4];
  logic                         zflag;

  // ---------------------------------------------------------------------
  // Accept-time count update (uses cleared base on start_req)
  // ---------------------------------------------------------------------
  logic [CW-1:0]   cnt_base, cnt_sum;
  logic            cnt_clip;
  always_comb begin
    cnt_base = start_req ? '0 : CW'(count);
    cnt_sum  = cnt_base + CW'(weight);
    cnt_clip = mode && (cnt_sum > CNT_MAX);
  end

  // ---------------------------------------------------------------------
  // Saturating add of one product into its sum
  // ---------------------------------------------------------------------
  logic signed [SUM_BITS:0]   add_ext;
  logic signed [SUM_BITS-1:0] add_sat;
  logic                       add_ovf;
  logic [SUM_BITS-1:0]        add_mag;
  logic [SUM_BITS-1:0]        m_new;
  always_comb begin
    add_ext = {sums[idx][SUM_BITS-1], sums[idx]} + (SUM_BITS+1)'(prod);
    add_ovf = add_ext[SUM_BITS] != add_ext[SUM_BITS-1];
    if (add_ovf) begin
      add_sat = add_ext[SUM_BITS] ? {1'b1, {(SUM_BITS-1){1'b0}}}
                                  : {1'b0, {(SUM_BITS-1){1'b1}}};
    end else begin
      add_sat = add_ext[SUM_BITS-1:0];
    end
    add_mag = add_sat[SUM_BITS-1] ? SUM_BITS'(-add_sat) : SUM_BITS'(add_sat);
    m_new   = (add_mag > mmax) ? add_mag : mmax;
  end

  // ---------------------------------------------------------------------
  // Square root step and divide step
  // ---------------------------------------------------------------------
  logic [63:0] rbit, rtrial;
  logic        rge;
  logic [32:0] dsub;
  logic        dge;
  logic [QB-1:0]  qfin;
  logic [QX-1:0]  qext;
  logic signed [QW-1:0] qsat;
  always_comb begin
    rbit   = 64'd1 << {k, 1'b0};
    rtrial = res + rbit;
    rge    = rv >= rtrial;
    dge    = rem >= 33'(len);
    dsub   = dge ? rem - 33'(len) : rem;
    qfin   = {quo[QB-2:0], dge};
    qext   = QX'(qfin);
    if (sums[idx][SUM_BITS-1]) begin
      qsat = (qext > QX'(32768)) ? QW'(-32768) : QW'(-qext);
    end else begin
      qsat = (qext > QX'(32767)) ? QW'(32767) : QW'(qext);
    end
  end

  assign in_ready = (state == S_IDLE);

  // ---------------------------------------------------------------------
  // Output valid: raise when a result loads, drop when it is taken
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      idx       <= '0;
      count     <= '0;
      clip      <= 1'b0;
      for (int i = 0; i < 4; i++) sums[i] <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            qin[0] <= in_w;
            qin[1] <= in_x;
            qin[2] <= in_y;
            qin[3] <= in_z;
            wgt    <= weight;
            idx    <= '0;
            mmax   <= '0;
            if (start_req) begin
              for (int i = 0; i < 4; i++) sums[i] <= '0;
            end
            if (mode) begin
              count <= cnt_clip ? CNT_MAX[COUNT_BITS-1:0] : cnt_sum[COUNT_BITS-1:0];
            end else if (start_req) begin
              count <= '0;
            end
            clip  <= (start_req ? 1'b0 : clip) | cnt_clip;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod  <= qin[idx] * $signed({1'b0, wgt});
          state <= S_ADD;
        end
        S_ADD: begin
          sums[idx] <= add_sat;
          mag[idx]  <= add_mag;
          mmax      <= m_new;
          if (add_ovf) clip <= 1'b1;
          idx <= idx + 2'd1;
          if (idx == 2'd3) begin
            if (m_new == '0) begin
              zflag <= 1'b1;
              for (int i = 0; i < 4; i++) mres[i] <= '0;
              state <= S_DONE;
            end else begin
              zflag <= 1'b0;
              state <= S_NORM;
            end
          end else begin
            state <= S_MUL;
          end
        end
        S_NORM: begin
          // Shift all four magnitudes together; right shifts truncate.
          if (mmax[SUM_BITS-1:NORM_MSB+1] != '0) begin
            mmax <= mmax >> 1;
            for (int i = 0; i < 4; i++) mag[i] <= mag[i] >> 1;
          end else if (!mmax[NORM_MSB]) begin
            mmax <= mmax << 1;
            for (int i = 0; i < 4; i++) mag[i] <= mag[i] << 1;
          end else begin
            acc   <= '0;
            idx   <= '0;
            state <= S_SQ;
          end
        end
        S_SQ: begin
          sq    <= mag[idx][NORM_MSB:0] * mag[idx][NORM_MSB:0];
          state <= S_SQACC;
        end
        S_SQACC: begin
          idx <= idx + 2'd1;
          if (idx == 2'd3) begin
            rv    <= 64'(acc + 62'(sq));
            res   <= '0;
            k     <= 5'd31;
            state <= S_ROOT;
          end else begin
            acc   <= acc + 62'(sq);
            state <= S_SQ;
          end
        end
        S_ROOT: begin
          if (rge) begin
            rv  <= rv - rtrial;
            res <= (res >> 1) + rbit;
          end else begin
            res <= res >> 1;
          end
          k <= k - 5'd1;
          if (k == 5'd0) begin
            len   <= rge ? 31'((res >> 1) + rbit) : 31'(res >> 1);
            idx   <= '0;
            rem   <= 33'(mag[0][NORM_MSB:0]);
            quo   <= '0;
            dcnt  <= DCW'(FRAC_BITS);
            state <= S_DIV;
          end
        end
        S_DIV: begin
          // Restoring divide, one quotient bit per cycle.
          if (dcnt == '0) begin
            mres[idx] <= qsat;
            idx       <= idx + 2'd1;
            rem       <= 33'(mag[idx + 2'd1][NORM_MSB:0]);
            quo       <= '0;
            dcnt      <= DCW'(FRAC_BITS);
            if (idx == 2'd3) state <= S_DONE;
          end else begin
            quo  <= qfin;
            rem  <= {dsub[31:0], 1'b0};
            dcnt <= dcnt - DCW'(1);
          end
        end
        S_DONE: begin
          // Hold until the output register is free.
          if (!out_valid || out_ready) begin
            mean_w     <= mres[0];
            mean_x     <= mres[1];
            mean_y     <= mres[2];
            mean_z     <= mres[3];
            zero_sum   <= zflag;
            saturated  <= clip;
            atom_count <= CNT_OUT'(count);
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_len_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> ((len >> NORM_MSB) != '0))
    else $error("root below normalized range");

  a_norm_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_SQ) |-> (mmax[NORM_MSB] && (mmax >> (NORM_MSB + 1)) == '0))
    else $error("squares taken before normalization finished");

  a_zero_out: assert property (@(posedge clk) disable iff (rst)
    (out_valid && zero_sum) |->
      (mean_w == '0 && mean_x == '0 && mean_y == '0 && mean_z == '0))
    else $error("zero sum with nonzero mean");

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    (CW'(count) <= CNT_MAX))
    else $error("count beyond its ceiling");

endmodule
